>>> design/rlpe_pkg.sv
// shared types and constants of the run length pair encoder
package rlpe_pkg;

	localparam int MAX_RUN = 256;
	localparam int RUN_LEN_W = $clog2(MAX_RUN + 1);
	localparam int BYTE_W = 8;
	localparam int LIMIT_W = 16;
	localparam int BW_W = 17;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic              overflow;
		logic              last_pair;
		logic [BYTE_W-1:0] pair_value;
		logic [BYTE_W-1:0] count_minus_one;
	} result_t;

	// one queue entry: the results caused by one item, first in r0
	typedef struct packed {
		logic    two;
		result_t r1;
		result_t r0;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	localparam result_t OVF_RESULT = '{overflow: 1'b1, last_pair: 1'b1,
		pair_value: '0, count_minus_one: '0};

endpackage

>>> design/rlpe_front.sv
// front end: run tracking, output byte accounting and result classification
module rlpe_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic [rlpe_pkg::BYTE_W-1:0]     data_byte,
	input  logic                            last_byte,
	input  logic                            cfg_we,
	input  logic [rlpe_pkg::LIMIT_W-1:0]    cfg_limit,
	output logic                            push,
	output rlpe_pkg::entry_t                push_entry
);

	logic [rlpe_pkg::BYTE_W-1:0]    run_byte_q;
	logic [rlpe_pkg::RUN_LEN_W-1:0] run_len_q;
	logic [rlpe_pkg::BW_W-1:0]      bw_q;
	logic                           failed_q;
	logic [rlpe_pkg::LIMIT_W-1:0]   limit_q;

	logic                           close;
	logic                           ov1;
	logic                           ov2;
	logic [rlpe_pkg::BW_W-1:0]      bw_mid;
	logic [rlpe_pkg::RUN_LEN_W-1:0] len_mid;
	logic [rlpe_pkg::BYTE_W-1:0]    byte_mid;
	logic                           new_run;
	rlpe_pkg::result_t              closed_pair;
	rlpe_pkg::result_t              final_res;

	always_comb begin
		close = (run_len_q != '0) && ((data_byte != run_byte_q) ||
			(run_len_q >= rlpe_pkg::RUN_LEN_W'(rlpe_pkg::MAX_RUN)));
		ov1 = ({1'b0, bw_q} + (rlpe_pkg::BW_W+1)'(2)) >
			(rlpe_pkg::BW_W+1)'(limit_q);
		bw_mid = close ? rlpe_pkg::BW_W'(bw_q + rlpe_pkg::BW_W'(2)) : bw_q;
		new_run = close || (run_len_q == '0);
		len_mid = new_run ? rlpe_pkg::RUN_LEN_W'(1) :
			rlpe_pkg::RUN_LEN_W'(run_len_q + rlpe_pkg::RUN_LEN_W'(1));
		byte_mid = new_run ? data_byte : run_byte_q;
		ov2 = ({1'b0, bw_mid} + (rlpe_pkg::BW_W+1)'(2)) >
			(rlpe_pkg::BW_W+1)'(limit_q);

		closed_pair.overflow = 1'b0;
		closed_pair.last_pair = 1'b0;
		closed_pair.pair_value = run_byte_q;
		closed_pair.count_minus_one =
			rlpe_pkg::BYTE_W'(run_len_q - rlpe_pkg::RUN_LEN_W'(1));

		if (ov2) begin
			final_res = rlpe_pkg::OVF_RESULT;
		end else begin
			final_res.overflow = 1'b0;
			final_res.last_pair = 1'b1;
			final_res.pair_value = byte_mid;
			final_res.count_minus_one =
				rlpe_pkg::BYTE_W'(len_mid - rlpe_pkg::RUN_LEN_W'(1));
		end

		push = 1'b0;
		push_entry.two = 1'b0;
		push_entry.r0 = closed_pair;
		push_entry.r1 = final_res;
		if (accept && !failed_q) begin
			if (close && ov1) begin
				push = 1'b1;
				push_entry.r0 = rlpe_pkg::OVF_RESULT;
			end else if (close) begin
				push = 1'b1;
				push_entry.two = last_byte;
			end else if (last_byte) begin
				push = 1'b1;
				push_entry.r0 = final_res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '1;
		end else if (cfg_we) begin
			limit_q <= cfg_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_byte_q <= '0;
			run_len_q <= '0;
			bw_q <= '0;
			failed_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				// packet ends: normal, overflowed or swallowed
				run_byte_q <= '0;
				run_len_q <= '0;
				bw_q <= '0;
				failed_q <= 1'b0;
			end else if (!failed_q) begin
				if (close && ov1) begin
					failed_q <= 1'b1;
				end else begin
					run_byte_q <= byte_mid;
					run_len_q <= len_mid;
					bw_q <= bw_mid;
				end
			end
		end
	end

endmodule

>>> design/rlpe_queue.sv
// small entry queue between front and back end
module rlpe_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rlpe_pkg::entry_t    push_entry,
	input  logic                pop,
	output rlpe_pkg::entry_t    head,
	output rlpe_pkg::q_status_t status
);

	rlpe_pkg::entry_t            entries_q [rlpe_pkg::QDEPTH];
	logic [rlpe_pkg::QPTR_W-1:0] wr_q;
	logic [rlpe_pkg::QPTR_W-1:0] rd_q;
	logic [rlpe_pkg::QCNT_W-1:0] cnt_q;

	assign head = entries_q[rd_q];
	assign status.full = (cnt_q == rlpe_pkg::QCNT_W'(rlpe_pkg::QDEPTH));
	assign status.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + rlpe_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + rlpe_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + rlpe_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - rlpe_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

>>> design/rlpe_back.sv
// back end: output register that plays out one or two results per entry
module rlpe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rlpe_pkg::q_status_t q_status,
	input  rlpe_pkg::entry_t    q_head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output rlpe_pkg::result_t   out_result
);

	rlpe_pkg::entry_t ent_q;
	logic             valid_q;
	logic             sel_q;
	logic             fire;
	logic             done;

	assign fire = valid_q && out_ready;
	assign done = !ent_q.two || sel_q;
	assign pop = !q_status.empty && (!valid_q || (fire && done));
	assign out_valid = valid_q;
	assign out_result = sel_q ? ent_q.r1 : ent_q.r0;

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
			sel_q <= 1'b0;
		end else if (fire) begin
			if (done) begin
				valid_q <= 1'b0;
				sel_q <= 1'b0;
			end else begin
				sel_q <= 1'b1;
			end
		end
	end

endmodule

>>> design/run_length_pair_encoder_top.sv
// top level of the run length pair encoder
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata[7:0] data byte, tlast last byte
// m_*       out  m_tvalid/m_tready  tdata count-1 and value, tlast last pair, tuser overflow
// cfg_*     in   cfg_valid/cfg_ready cfg_data output limit in bytes
//
// one input item per cycle while the queue is not full; the front end updates the run, the byte count and
// the limit check in the accepting cycle and queues the item's results
// a last byte that also closes a run yields two results, which the output
// register plays out one after the other; the 4-entry queue absorbs these
// s_tready drops only while the queue is full, so a stalled output side
// backs up into the input once the output register and all four queue entries hold results
// reset clears run state and the queue, sets the limit to 65535; no clearing pass
module run_length_pair_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	// input byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] count_minus_one, [15:8] pair_value
	output logic        m_tlast,   // last_pair
	output logic        m_tuser,   // overflow
	// limit register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic                accept;
	logic                push;
	logic                pop;
	rlpe_pkg::entry_t    push_entry;
	rlpe_pkg::entry_t    q_head;
	rlpe_pkg::q_status_t q_status;
	rlpe_pkg::result_t   out_result;

	// the limit register takes writes in any cycle
	assign cfg_ready = 1'b1;
	// one entry slot covers every result an item can cause
	assign s_tready = !q_status.full;
	assign accept = s_tvalid && s_tready;

	rlpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (s_tdata),
		.last_byte  (s_tlast),
		.cfg_we     (cfg_valid),
		.cfg_limit  (cfg_data),
		.push       (push),
		.push_entry (push_entry)
	);

	rlpe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (q_head),
		.status     (q_status)
	);

	rlpe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.q_head     (q_head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (out_result)
	);

	// pack result fields onto the stream
	assign m_tdata = {out_result.pair_value, out_result.count_minus_one};
	assign m_tlast = out_result.last_pair;
	assign m_tuser = out_result.overflow;

`ifndef SYNTHESIS
	// the front end never writes into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("push into full queue");

	// an overflow result ends the packet and carries no pair
	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == 16'd0)))
		else $error("malformed overflow result");

	// the back end only pops an entry that is there
	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");
`endif

endmodule

>>> verif/rlpe_checker.sv
// scoreboard for the run length pair encoder: predicts pairs from the byte stream and checks them
`timescale 1ns / 100ps

module rlpe_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [7:0] count_minus_one, [15:8] pair_value
	input  logic        m_tlast,   // last_pair
	input  logic        m_tuser,   // overflow
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pairs_due,
	output int          bytes_seen,
	output int          pairs_seen,
	output int          overflows_seen,
	output int          limit_writes
);

	logic [rlpe_pkg::LIMIT_W-1:0]   limit_bytes;
	logic [rlpe_pkg::BYTE_W-1:0]    run_value;
	logic [rlpe_pkg::RUN_LEN_W-1:0] run_count;
	logic [rlpe_pkg::BW_W-1:0]      used_bytes;
	logic                           swallowing;
	rlpe_pkg::result_t              due_q[$];

	// queues one pair, or the overflow result when the pair does not fit
	function automatic bit push_pair(input logic [rlpe_pkg::RUN_LEN_W-1:0] len,
			input logic [rlpe_pkg::BYTE_W-1:0] val, input logic last);
		rlpe_pkg::result_t r;
		if (int'(used_bytes) + 2 > int'(limit_bytes)) begin
			due_q.push_back(rlpe_pkg::OVF_RESULT);
			return 1'b0;
		end
		used_bytes = used_bytes + rlpe_pkg::BW_W'(2);
		r.count_minus_one = rlpe_pkg::BYTE_W'(len - rlpe_pkg::RUN_LEN_W'(1));
		r.pair_value = val;
		r.last_pair = last;
		r.overflow = 1'b0;
		due_q.push_back(r);
		return 1'b1;
	endfunction

	function automatic void end_packet();
		run_value = '0;
		run_count = '0;
		used_bytes = '0;
		swallowing = 1'b0;
	endfunction

	function automatic void encode_byte(input logic [rlpe_pkg::BYTE_W-1:0] b,
			input logic last);
		if (swallowing) begin
			if (last)
				end_packet();
			return;
		end
		// close the open run on a new value or when it is full
		if (run_count != '0 && (b != run_value ||
				run_count >= rlpe_pkg::RUN_LEN_W'(rlpe_pkg::MAX_RUN))) begin
			if (!push_pair(run_count, run_value, 1'b0)) begin
				if (last)
					end_packet();
				else
					swallowing = 1'b1;
				return;
			end
			run_count = '0;
		end
		if (run_count == '0) begin
			run_value = b;
			run_count = rlpe_pkg::RUN_LEN_W'(1);
		end else begin
			run_count = run_count + rlpe_pkg::RUN_LEN_W'(1);
		end
		if (last) begin
			void'(push_pair(run_count, run_value, 1'b1));
			end_packet();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rlpe_pkg::result_t got;
		rlpe_pkg::result_t want;
		if (!arst_n) begin
			limit_bytes = '1;
			end_packet();
			due_q.delete();
			fail_count = 0;
			pairs_due = 0;
			bytes_seen = 0;
			pairs_seen = 0;
			overflows_seen = 0;
			limit_writes = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{overflow: m_tuser, last_pair: m_tlast,
					pair_value: m_tdata[15:8], count_minus_one: m_tdata[7:0]};
				if (got.overflow)
					overflows_seen++;
				else
					pairs_seen++;
				if (due_q.size() == 0) begin
					$display("%0t: unexpected result ovf=%0b last=%0b value=%02h count-1=%02h",
						$time, got.overflow, got.last_pair, got.pair_value,
						got.count_minus_one);
					fail_count++;
				end else begin
					want = due_q.pop_front();
					if (got !== want) begin
						$display("%0t: result mismatch, expected ovf=%0b last=%0b ",
							$time, want.overflow, want.last_pair,
							"value=%02h count-1=%02h, ",
							want.pair_value, want.count_minus_one,
							"got ovf=%0b last=%0b value=%02h count-1=%02h",
							got.overflow, got.last_pair,
							got.pair_value, got.count_minus_one);
						fail_count++;
					end
				end
			end
			// an item accepted with a limit write still sees the old limit
			if (s_tvalid && s_tready) begin
				encode_byte(s_tdata, s_tlast);
				bytes_seen++;
			end
			if (cfg_valid && cfg_ready) begin
				limit_bytes = cfg_data;
				limit_writes++;
			end
			pairs_due = due_q.size();
		end
	end

endmodule

>>> verif/run_length_pair_encoder_top_tb.sv
// testbench top for the run length pair encoder: byte stimulus, limit writes and verdict
`timescale 1ns / 100ps

module run_length_pair_encoder_top_tb;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tlast;   // last_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [7:0] count_minus_one, [15:8] pair_value
	logic        m_tlast;   // last_pair
	logic        m_tuser;   // overflow
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	int fail_count;
	int pairs_due;
	int bytes_seen;
	int pairs_seen;
	int overflows_seen;
	int limit_writes;

	int bytes_sent;
	// when set the sender offers bytes back to back for the current packet
	bit burst;

	run_length_pair_encoder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// watches all three channels and keeps the expected pairs
	rlpe_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.m_tuser        (m_tuser),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pairs_due      (pairs_due),
		.bytes_seen     (bytes_seen),
		.pairs_seen     (pairs_seen),
		.overflows_seen (overflows_seen),
		.limit_writes   (limit_writes)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// reset asserted at start, released on a clock edge, never asserted again
	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("run_length_pair_encoder_top regression: fail");
		$finish;
	end

	// result side: random stalls per item, stall-free stretches, and two long hold-offs
	// that back the queue up into s_tready
	initial begin : result_sink
		int wait_cycles;
		int fast_left;
		int taken;
		m_tready <= 1'b0;
		fast_left = 0;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if (taken == 80 || taken == 600) begin
				m_tready <= 1'b0;
				repeat (200) @(posedge clk);
			end
			if (fast_left > 0) begin
				fast_left--;
				wait_cycles = 0;
			end else if ($urandom_range(0, 15) == 0) begin
				fast_left = $urandom_range(10, 30);
				wait_cycles = 0;
			end else begin
				wait_cycles = $urandom_range(0, 11);
			end
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
		end
	end

	// offers one byte after a random gap (none in a burst) and waits until it is taken
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// n copies of one byte, the last one optionally closing the packet
	task automatic send_run(input logic [7:0] b, input int n, input logic last);
		for (int i = 0; i < n; i++)
			send_byte(b, last && i == n - 1);
	endtask

	// packet drawn from a small palette so that runs form; a few are pure noise
	task automatic send_random_packet();
		int len;
		bit noisy;
		logic [7:0] pal[3];
		logic [7:0] b;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
		noisy = ($urandom_range(0, 9) == 0);
		burst = ($urandom_range(0, 3) == 0);
		foreach (pal[i])
			pal[i] = 8'($urandom);
		b = pal[0];
		for (int i = 0; i < len; i++) begin
			if (noisy)
				b = 8'($urandom);
			else if ($urandom_range(0, 9) < 4)
				b = pal[$urandom_range(0, 2)];
			send_byte(b, i == len - 1);
		end
		burst = 1'b0;
	endtask

	task automatic send_random(input int count);
		int stop_at;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at)
			send_random_packet();
	endtask

	// stop offering, wait for every expected pair, then let the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pairs_due != 0);
		repeat (8) @(posedge clk);
	endtask

	// limit writes happen only with nothing in flight
	task automatic set_limit(input logic [15:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : byte_source
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		bytes_sent = 0;
		burst = 1'b0;
		@(posedge arst_n);
		@(posedge clk);

		// reset limit: single-byte packet, two pairs on the last byte, one long run
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_run(8'h5A, 3, 1'b1);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h3C, 1'b1);
		// 257 equal bytes: the full run closes and the last byte opens its own
		send_run(8'h81, 257, 1'b1);
		send_random(60);

		// limit 0: every pair overflows, on the last byte and in mid-packet
		set_limit(16'd0);
		send_byte(8'h11, 1'b1);
		send_byte(8'h22, 1'b0);
		send_byte(8'h22, 1'b0);
		send_byte(8'h33, 1'b0);
		send_byte(8'h44, 1'b0);   // swallowed
		send_byte(8'h55, 1'b1);   // swallowed, ends the packet
		send_byte(8'h66, 1'b1);
		send_random(30);

		// room for exactly one pair
		set_limit(16'd2);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h04, 1'b1);
		send_run(8'h07, 2, 1'b1);
		send_byte(8'h08, 1'b0);
		send_byte(8'h09, 1'b1);   // closing pair fits, final pair overflows
		send_random(30);

		// odd limit
		set_limit(16'd3);
		send_random(30);

		set_limit(16'($urandom_range(4, 24)));
		send_random(80);

		// full limit, run crossing the 256 boundary twice
		set_limit(16'hFFFF);
		send_run(8'hC3, 513, 1'b1);
		send_random(40);

		set_limit(16'($urandom_range(0, 65535)));
		send_random(80);

		set_limit(16'd1);
		send_random(20);

		set_limit(16'($urandom_range(6, 40)));
		send_random(60);

		drain();
		repeat (16) @(posedge clk);
		$display("covered %0d bytes in, %0d pairs and %0d overflow results checked",
			bytes_seen, pairs_seen, overflows_seen);
		$display("limit rewritten %0d times, from 0 up to 65535, with runs past 256 bytes",
			limit_writes);
		if (fail_count == 0)
			$display("run_length_pair_encoder_top regression: pass");
		else
			$display("run_length_pair_encoder_top regression: fail");
		$finish;
	end

endmodule
